[rtl/dedup_top_k_server_list_macros.svh]
// assertion macros used by the checker file
`ifndef DEDUP_TOP_K_SERVER_LIST_MACROS_SVH
`define DEDUP_TOP_K_SERVER_LIST_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define DTK_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dtk check failed");

// next-cycle implication
`define DTK_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dtk check failed");

`endif

[rtl/dtk_pkg.sv]
package dtk_pkg;

	localparam int MAX_SERVERS_DEF = 4;
	localparam int ADDR_W = 64;
	localparam int LIFE_W = 32;
	localparam int KEPT_W = 3;

	// operation codes
	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;

	typedef enum logic [1:0] {
		OUT_NONE = 2'd0,
		OUT_NEW  = 2'd1,
		OUT_DUP  = 2'd2,
		OUT_DROP = 2'd3
	} outcome_t;

	typedef enum logic [1:0] {
		EM_ZERO,
		EM_WORK,
		EM_ENTRY
	} emit_sel_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_FULLCHK,
		S_BUBBLE,
		S_EMIT,
		S_ZERO,
		S_READ
	} state_t;

	typedef struct packed {
		logic      accept;
		logic      clear_cnt;
		logic      idx_inc;
		logic      merge;
		logic      grow;
		logic      set_last;
		logic      rd_prev;
		logic      shift;
		logic      place;
		logic      emit;
		emit_sel_t emit_sel;
		outcome_t  outcome;
	} cmd_t;

	typedef struct packed {
		logic match;
		logic idx_lt_cnt;
		logic idx_zero;
		logic idx_is_last;
		logic full;
		logic empty;
		logic w_outranks;
		logic out_free;
	} status_t;

	// rank order: larger lifetime first, then larger 128-bit address
	function automatic logic outranks(
		input logic [ADDR_W-1:0] ah,
		input logic [ADDR_W-1:0] al,
		input logic [LIFE_W-1:0] at,
		input logic [ADDR_W-1:0] bh,
		input logic [ADDR_W-1:0] bl,
		input logic [LIFE_W-1:0] bt
	);
		logic r;
		if (at != bt) begin
			r = (at > bt);
		end else begin
			r = ({ah, al} > {bh, bl});
		end
		return r;
	endfunction

endpackage

[rtl/dtk_ctrl.sv]
module dtk_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [1:0]       operation,
	input  dtk_pkg::status_t st,
	output logic             in_ready,
	output dtk_pkg::cmd_t    cmd
);

	dtk_pkg::state_t   state_q, state_d;
	dtk_pkg::outcome_t outcome_q, outcome_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= dtk_pkg::S_IDLE;
			outcome_q <= dtk_pkg::OUT_NONE;
		end else begin
			state_q   <= state_d;
			outcome_q <= outcome_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			dtk_pkg::S_IDLE: begin
				if (in_valid) begin
					case (operation)
						dtk_pkg::OP_INSERT: state_d = dtk_pkg::S_SCAN;
						dtk_pkg::OP_READ:   state_d = dtk_pkg::S_READ;
						default:            state_d = dtk_pkg::S_ZERO;
					endcase
				end
			end
			dtk_pkg::S_SCAN: begin
				if (!st.idx_lt_cnt && st.full) begin
					state_d = dtk_pkg::S_FULLCHK;
				end else if (!st.idx_lt_cnt || st.match) begin
					state_d = dtk_pkg::S_BUBBLE;
				end
			end
			dtk_pkg::S_FULLCHK: begin
				state_d = st.w_outranks ? dtk_pkg::S_BUBBLE : dtk_pkg::S_ZERO;
			end
			dtk_pkg::S_BUBBLE: begin
				if (st.idx_zero || !st.w_outranks) begin
					state_d = dtk_pkg::S_EMIT;
				end
			end
			dtk_pkg::S_EMIT, dtk_pkg::S_ZERO: begin
				if (st.out_free) begin
					state_d = dtk_pkg::S_IDLE;
				end
			end
			dtk_pkg::S_READ: begin
				if (st.out_free && (st.empty || st.idx_is_last)) begin
					state_d = dtk_pkg::S_IDLE;
				end
			end
			default: state_d = dtk_pkg::S_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		outcome_d = outcome_q;
		case (state_q)
			dtk_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept    = 1'b1;
					cmd.clear_cnt = (operation == dtk_pkg::OP_CLEAR);
					outcome_d     = dtk_pkg::OUT_NONE;
				end
			end
			dtk_pkg::S_SCAN: begin
				if (st.idx_lt_cnt) begin
					if (st.match) begin
						cmd.merge = 1'b1;
						outcome_d = dtk_pkg::OUT_DUP;
					end else begin
						cmd.idx_inc = 1'b1;
					end
				end else if (!st.full) begin
					cmd.grow  = 1'b1;
					outcome_d = dtk_pkg::OUT_NEW;
				end else begin
					cmd.set_last = 1'b1;
				end
			end
			dtk_pkg::S_FULLCHK: begin
				outcome_d = st.w_outranks ? dtk_pkg::OUT_NEW : dtk_pkg::OUT_DROP;
			end
			dtk_pkg::S_BUBBLE: begin
				cmd.rd_prev = 1'b1;
				if (st.idx_zero || !st.w_outranks) begin
					cmd.place = 1'b1;
				end else begin
					cmd.shift = 1'b1;
				end
			end
			dtk_pkg::S_EMIT: begin
				if (st.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = dtk_pkg::EM_WORK;
					cmd.outcome  = outcome_q;
				end
			end
			dtk_pkg::S_ZERO: begin
				if (st.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = dtk_pkg::EM_ZERO;
					cmd.outcome  = outcome_q;
				end
			end
			dtk_pkg::S_READ: begin
				if (st.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = st.empty ? dtk_pkg::EM_ZERO : dtk_pkg::EM_ENTRY;
					cmd.outcome  = dtk_pkg::OUT_NONE;
					cmd.idx_inc  = 1'b1;
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

[rtl/dtk_datapath.sv]
module dtk_datapath #(
	parameter int MAX_SERVERS = dtk_pkg::MAX_SERVERS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [dtk_pkg::ADDR_W-1:0]  address_high,
	input  logic [dtk_pkg::ADDR_W-1:0]  address_low,
	input  logic [dtk_pkg::LIFE_W-1:0]  lifetime,
	input  dtk_pkg::cmd_t               cmd,
	output dtk_pkg::status_t            st,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [dtk_pkg::ADDR_W-1:0]  entry_high,
	output logic [dtk_pkg::ADDR_W-1:0]  entry_low,
	output logic [dtk_pkg::LIFE_W-1:0]  entry_lifetime,
	output logic                        entry_valid,
	output logic [dtk_pkg::KEPT_W-1:0]  kept_count,
	output logic [1:0]                  insert_outcome,
	output logic                        last
);

	localparam int CW = $clog2(MAX_SERVERS + 1);
	localparam int IW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;

	// entry store, one read and one write per cycle
	logic [dtk_pkg::ADDR_W-1:0] ent_high_q [MAX_SERVERS];
	logic [dtk_pkg::ADDR_W-1:0] ent_low_q  [MAX_SERVERS];
	logic [dtk_pkg::LIFE_W-1:0] ent_life_q [MAX_SERVERS];

	logic [dtk_pkg::ADDR_W-1:0] w_high_q, w_low_q;
	logic [dtk_pkg::LIFE_W-1:0] w_life_q;
	logic [CW-1:0]              cnt_q, idx_q, rd_ptr;

	logic [dtk_pkg::ADDR_W-1:0] rd_high, rd_low;
	logic [dtk_pkg::LIFE_W-1:0] rd_life;

	logic [dtk_pkg::ADDR_W-1:0] out_high_q, out_low_q;
	logic [dtk_pkg::LIFE_W-1:0] out_life_q;
	logic                       out_valid_q, out_ent_valid_q, out_last_q;
	logic [dtk_pkg::KEPT_W-1:0] out_kept_q;
	logic [1:0]                 out_outcome_q;

	assign rd_ptr  = cmd.rd_prev ? (idx_q - CW'(1)) : idx_q;
	assign rd_high = ent_high_q[rd_ptr[IW-1:0]];
	assign rd_low  = ent_low_q[rd_ptr[IW-1:0]];
	assign rd_life = ent_life_q[rd_ptr[IW-1:0]];

	always_comb begin
		st.match       = (rd_high == w_high_q) && (rd_low == w_low_q);
		st.idx_lt_cnt  = (idx_q < cnt_q);
		st.idx_zero    = (idx_q == '0);
		st.idx_is_last = (idx_q == (cnt_q - CW'(1)));
		st.full        = (cnt_q >= CW'(MAX_SERVERS));
		st.empty       = (cnt_q == '0);
		st.w_outranks  = dtk_pkg::outranks(w_high_q, w_low_q, w_life_q,
			rd_high, rd_low, rd_life);
		st.out_free    = !out_valid_q || out_ready;
	end

	// payload: store, working entry
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			w_high_q <= address_high;
			w_low_q  <= address_low;
			w_life_q <= lifetime;
		end else if (cmd.merge && (rd_life > w_life_q)) begin
			w_life_q <= rd_life;
		end
		if (cmd.shift) begin
			ent_high_q[idx_q[IW-1:0]] <= rd_high;
			ent_low_q[idx_q[IW-1:0]]  <= rd_low;
			ent_life_q[idx_q[IW-1:0]] <= rd_life;
		end else if (cmd.place) begin
			ent_high_q[idx_q[IW-1:0]] <= w_high_q;
			ent_low_q[idx_q[IW-1:0]]  <= w_low_q;
			ent_life_q[idx_q[IW-1:0]] <= w_life_q;
		end
	end

	// count and position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else begin
			if (cmd.clear_cnt) begin
				cnt_q <= '0;
			end else if (cmd.grow) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.accept) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + CW'(1);
			end else if (cmd.grow) begin
				idx_q <= cnt_q;
			end else if (cmd.set_last) begin
				idx_q <= CW'(MAX_SERVERS - 1);
			end else if (cmd.shift) begin
				idx_q <= idx_q - CW'(1);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_kept_q    <= dtk_pkg::KEPT_W'(cnt_q);
			out_outcome_q <= cmd.outcome;
			case (cmd.emit_sel)
				dtk_pkg::EM_WORK: begin
					out_high_q      <= w_high_q;
					out_low_q       <= w_low_q;
					out_life_q      <= w_life_q;
					out_ent_valid_q <= 1'b1;
					out_last_q      <= 1'b1;
				end
				dtk_pkg::EM_ENTRY: begin
					out_high_q      <= rd_high;
					out_low_q       <= rd_low;
					out_life_q      <= rd_life;
					out_ent_valid_q <= 1'b1;
					out_last_q      <= st.idx_is_last;
				end
				default: begin
					out_high_q      <= '0;
					out_low_q       <= '0;
					out_life_q      <= '0;
					out_ent_valid_q <= 1'b0;
					out_last_q      <= 1'b1;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign entry_high     = out_high_q;
	assign entry_low      = out_low_q;
	assign entry_lifetime = out_life_q;
	assign entry_valid    = out_ent_valid_q;
	assign kept_count     = out_kept_q;
	assign insert_outcome = out_outcome_q;
	assign last           = out_last_q;

endmodule

[rtl/dedup_top_k_server_list.sv]
// Sorted list of up to MAX_SERVERS server entries (128-bit address, 32-bit lifetime), ranked
// by lifetime then address, both descending, with duplicate addresses merged to the larger
// lifetime. One request is worked at a time. The entries sit in a small store with one read
// and one write per cycle, so the duplicate search and the re-sort each step one entry per
// cycle. An insert runs the search, a full-list check when the list is full and no entry
// matched, then the bubble-up and the emit step; a new entry dropped from a full list skips
// the bubble-up. Clear and unknown codes emit one empty result, a read-out one result per
// held entry (one for an empty list). A result still waiting on out_ready holds the emit
// step.
// Results leave through an output register, so a new request is taken while the last result
// of the previous one still waits on out_ready.
// There is no clearing pass after reset; the entry store is not reset, only the held count.
module dedup_top_k_server_list #(
	parameter int MAX_SERVERS = dtk_pkg::MAX_SERVERS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// request channel
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  operation,
	input  logic [dtk_pkg::ADDR_W-1:0]  address_high,
	input  logic [dtk_pkg::ADDR_W-1:0]  address_low,
	input  logic [dtk_pkg::LIFE_W-1:0]  lifetime,
	// result channel
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [dtk_pkg::ADDR_W-1:0]  entry_high,
	output logic [dtk_pkg::ADDR_W-1:0]  entry_low,
	output logic [dtk_pkg::LIFE_W-1:0]  entry_lifetime,
	output logic                        entry_valid,
	output logic [dtk_pkg::KEPT_W-1:0]  kept_count,
	output logic [1:0]                  insert_outcome,
	output logic                        last
);

	// command and status between sequencer and datapath
	dtk_pkg::cmd_t    cmd;
	dtk_pkg::status_t st;

	// sequencer: search, full-list check, bubble-up, emit, read-out walk
	dtk_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.operation (operation),
		.st        (st),
		.in_ready  (in_ready),
		.cmd       (cmd)
	);

	// entry store, working entry, rank comparator and output register
	dtk_datapath #(
		.MAX_SERVERS (MAX_SERVERS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.address_high   (address_high),
		.address_low    (address_low),
		.lifetime       (lifetime),
		.cmd            (cmd),
		.st             (st),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.entry_high     (entry_high),
		.entry_low      (entry_low),
		.entry_lifetime (entry_lifetime),
		.entry_valid    (entry_valid),
		.kept_count     (kept_count),
		.insert_outcome (insert_outcome),
		.last           (last)
	);

endmodule

[rtl/dtk_checker.sv]
`include "dedup_top_k_server_list_macros.svh"

module dtk_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [dtk_pkg::ADDR_W-1:0]  entry_high,
	input logic [dtk_pkg::ADDR_W-1:0]  entry_low,
	input logic [dtk_pkg::LIFE_W-1:0]  entry_lifetime,
	input logic                        entry_valid,
	input logic [1:0]                  insert_outcome,
	input logic                        last
);

	// stalled result holds
	`DTK_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(entry_high) && $stable(entry_low) && $stable(entry_lifetime) && $stable(last))

	// an empty result is always the only one of its request
	`DTK_ASSERT_NOW(a_empty_last, out_valid && !entry_valid, last)

	// insert results are single
	`DTK_ASSERT_NOW(a_insert_last, out_valid && (insert_outcome != dtk_pkg::OUT_NONE), last)

	// a dropped entry never shows as kept
	`DTK_ASSERT_NOW(a_drop_empty, out_valid && (insert_outcome == dtk_pkg::OUT_DROP), !entry_valid)

endmodule

bind dedup_top_k_server_list dtk_checker u_chk (.*);
